[rtl/csac_pkg.sv]
`timescale 1ns / 1ps

package csac_pkg;

	// request kinds
	localparam logic [1:0] REQ_KEY    = 2'd0;
	localparam logic [1:0] REQ_SAMPLE = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	// key codes
	localparam logic [2:0] KEY_SELECT = 3'd1;
	localparam logic [2:0] KEY_ALARM  = 3'd2;
	localparam logic [2:0] KEY_INC    = 3'd3;
	localparam logic [2:0] KEY_ENTER  = 3'd4;

	// modes
	localparam logic [1:0] MODE_SHOW  = 2'd0;
	localparam logic [1:0] MODE_TIME  = 2'd1;
	localparam logic [1:0] MODE_ALARM = 2'd2;

	// field selection
	localparam logic [2:0] FLD_YEAR   = 3'd0;
	localparam logic [2:0] FLD_MONTH  = 3'd1;
	localparam logic [2:0] FLD_DAY    = 3'd2;
	localparam logic [2:0] FLD_HOUR   = 3'd3;
	localparam logic [2:0] FLD_MINUTE = 3'd4;
	localparam logic [2:0] FLD_SECOND = 3'd5;
	localparam logic [2:0] FLD_WDAY   = 3'd6;

	localparam logic [15:0] BLINK_RESET = 16'd500;
	localparam logic [4:0]  ALARM_HOUR_RESET   = 5'd20;
	localparam logic [5:0]  ALARM_MINUTE_RESET = 6'd20;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] key_code;
		logic [6:0] rtc_year;
		logic [3:0] rtc_month;
		logic [4:0] rtc_day;
		logic [4:0] rtc_hour;
		logic [5:0] rtc_minute;
		logic [5:0] rtc_second;
		logic [2:0] rtc_weekday;
	} csac_item_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  field_select;
		logic        blank_selected;
		logic        write_time;
		logic        ring;
		logic        alarm_on;
		logic [4:0]  alarm_hour_out;
		logic [5:0]  alarm_minute_out;
		logic [35:0] time_word;
	} csac_result_t;

	// days in a month; zero for a month code outside 1..12
	function automatic logic [4:0] month_len(input logic [6:0] year, input logic [6:0] month);
		logic [4:0] len;
		case (month)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
			7'd4, 7'd6, 7'd9, 7'd11: len = 5'd30;
			7'd2: len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

[rtl/csac_in_stage.sv]
`timescale 1ns / 1ps

module csac_in_stage import csac_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  csac_item_t in_item,
	input  logic       out_free,
	output logic       fire,
	output csac_item_t item_s1
);

	logic valid_s1;
	logic free_s1;

	assign free_s1  = !valid_s1 || out_free;
	assign in_stall = !free_s1;
	assign fire     = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (free_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && free_s1) begin
			item_s1 <= in_item;
		end
	end

endmodule

[rtl/csac_core.sv]
`timescale 1ns / 1ps

module csac_core import csac_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_data,
	input  logic         fire,
	input  csac_item_t   item,
	output csac_result_t result
);

	logic [15:0] blink_q;
	logic [1:0]  mode_q;
	logic [2:0]  sel_q;
	logic [6:0]  year_q;
	logic [3:0]  month_q;
	logic [6:0]  day_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic [2:0]  wday_q;
	logic [4:0]  al_hour_q;
	logic [5:0]  al_minute_q;
	logic        al_en_q;
	logic        ringing_q;
	logic        last_match_q;
	logic [15:0] tick_q;
	logic        blank_q;

	logic [1:0]  mode_n;
	logic [2:0]  sel_n;
	logic [6:0]  t_year, t_month, t_day, t_hour, t_minute, t_second, t_wday;
	logic [4:0]  len;
	logic [4:0]  al_hour_n;
	logic [5:0]  al_minute_n;
	logic        al_en_n;
	logic        ringing_n;
	logic        match;
	logic        commit;
	logic [15:0] tick_n;
	logic [15:0] tick_inc;
	logic        blank_n;

	always_comb begin
		mode_n      = mode_q;
		sel_n       = sel_q;
		t_year      = year_q;
		t_month     = {3'd0, month_q};
		t_day       = day_q;
		t_hour      = {2'd0, hour_q};
		t_minute    = {1'd0, minute_q};
		t_second    = {1'd0, second_q};
		t_wday      = {4'd0, wday_q};
		al_hour_n   = al_hour_q;
		al_minute_n = al_minute_q;
		al_en_n     = al_en_q;
		ringing_n   = ringing_q;
		commit      = 1'b0;
		tick_n      = tick_q;
		blank_n     = blank_q;
		tick_inc    = tick_q + 16'd1;
		len         = 5'd0;

		case (item.req_type)
			REQ_KEY: begin
				if (ringing_q) begin
					// silence only
					if (item.key_code == KEY_ENTER) ringing_n = 1'b0;
				end else begin
					case (item.key_code)
						KEY_SELECT: begin
							if (mode_q == MODE_SHOW) begin
								mode_n = MODE_TIME;
								sel_n  = FLD_YEAR;
							end else if (mode_q == MODE_TIME) begin
								sel_n = (sel_q >= FLD_WDAY) ? FLD_YEAR : sel_q + 3'd1;
							end else begin
								sel_n = (sel_q == FLD_MINUTE) ? FLD_HOUR : FLD_MINUTE;
							end
						end
						KEY_ALARM: begin
							if (mode_q == MODE_SHOW) begin
								mode_n = MODE_ALARM;
								sel_n  = FLD_HOUR;
							end
						end
						KEY_INC: begin
							if (mode_q == MODE_TIME) begin
								case (sel_q)
									FLD_YEAR:   t_year   = t_year + 7'd1;
									FLD_MONTH:  t_month  = t_month + 7'd1;
									FLD_DAY:    t_day    = t_day + 7'd1;
									FLD_HOUR:   t_hour   = t_hour + 7'd1;
									FLD_MINUTE: t_minute = t_minute + 7'd1;
									FLD_SECOND: t_second = t_second + 7'd1;
									FLD_WDAY:   t_wday   = t_wday + 7'd1;
									default: ;
								endcase
								// wrap every field, not only the stepped one
								if (t_year > 7'd99) t_year = 7'd0;
								if (t_month > 7'd12) t_month = 7'd1;
								len = month_len(t_year, t_month);
								if (len != 5'd0 && t_day > {2'd0, len}) t_day = 7'd1;
								if (t_hour > 7'd23) t_hour = 7'd0;
								if (t_minute > 7'd59) t_minute = 7'd0;
								if (t_second > 7'd59) t_second = 7'd0;
								if (t_wday > 7'd7) t_wday = 7'd1;
							end else if (mode_q == MODE_ALARM) begin
								if (sel_q == FLD_HOUR) begin
									al_hour_n = (al_hour_q >= 5'd23) ? 5'd0 : al_hour_q + 5'd1;
								end else if (sel_q == FLD_MINUTE) begin
									al_minute_n = (al_minute_q >= 6'd59) ? 6'd0
										: al_minute_q + 6'd1;
								end
							end
						end
						KEY_ENTER: begin
							if (mode_q == MODE_TIME) begin
								mode_n = MODE_SHOW;
								commit = 1'b1;
							end else if (mode_q == MODE_ALARM) begin
								mode_n  = MODE_SHOW;
								al_en_n = 1'b1;
							end else begin
								al_en_n = !al_en_q;
							end
						end
						default: ;
					endcase
				end
			end
			REQ_SAMPLE: begin
				// keep the edited time outside show mode
				if (mode_q == MODE_SHOW) begin
					t_year   = item.rtc_year;
					t_month  = {3'd0, item.rtc_month};
					t_day    = {2'd0, item.rtc_day};
					t_hour   = {2'd0, item.rtc_hour};
					t_minute = {1'd0, item.rtc_minute};
					t_second = {1'd0, item.rtc_second};
					t_wday   = {4'd0, item.rtc_weekday};
				end
			end
			REQ_TICK: begin
				if (tick_inc >= blink_q) begin
					tick_n  = 16'd0;
					blank_n = !blank_q;
				end else begin
					tick_n = tick_inc;
				end
			end
			default: ;
		endcase

		match = (t_hour[4:0] == al_hour_n) && (t_minute[5:0] == al_minute_n)
			&& (t_second[5:0] == 6'd0);
		if (match && !last_match_q && al_en_n) ringing_n = 1'b1;

		result.mode             = mode_n;
		result.field_select     = sel_n;
		result.blank_selected   = blank_n && (mode_n != MODE_SHOW);
		result.write_time       = commit;
		result.ring             = ringing_n;
		result.alarm_on         = al_en_n;
		result.alarm_hour_out   = al_hour_n;
		result.alarm_minute_out = al_minute_n;
		result.time_word        = {t_wday[2:0], t_second[5:0], t_minute[5:0], t_hour[4:0],
			t_day[4:0], t_month[3:0], t_year};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_q <= BLINK_RESET;
		end else if (cfg_we) begin
			blink_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_SHOW;
			sel_q        <= FLD_YEAR;
			year_q       <= 7'd0;
			month_q      <= 4'd1;
			day_q        <= 7'd1;
			hour_q       <= 5'd0;
			minute_q     <= 6'd0;
			second_q     <= 6'd0;
			wday_q       <= 3'd1;
			al_hour_q    <= ALARM_HOUR_RESET;
			al_minute_q  <= ALARM_MINUTE_RESET;
			al_en_q      <= 1'b0;
			ringing_q    <= 1'b0;
			last_match_q <= 1'b0;
			tick_q       <= 16'd0;
			blank_q      <= 1'b1;
		end else if (fire) begin
			mode_q       <= mode_n;
			sel_q        <= sel_n;
			year_q       <= t_year;
			month_q      <= t_month[3:0];
			day_q        <= t_day;
			hour_q       <= t_hour[4:0];
			minute_q     <= t_minute[5:0];
			second_q     <= t_second[5:0];
			wday_q       <= t_wday[2:0];
			al_hour_q    <= al_hour_n;
			al_minute_q  <= al_minute_n;
			al_en_q      <= al_en_n;
			ringing_q    <= ringing_n;
			last_match_q <= match;
			tick_q       <= tick_n;
			blank_q      <= blank_n;
		end
	end

`ifndef SYNTHESIS
	a_ring_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ringing_q) |-> al_en_q)
		else $error("alarm started ringing while disabled");

	a_alarm_select: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_ALARM) |-> (sel_q == FLD_HOUR || sel_q == FLD_MINUTE))
		else $error("alarm set mode selects a field other than hour or minute");

	a_alarm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(al_hour_q <= 5'd23) && (al_minute_q <= 6'd59))
		else $error("alarm setting out of range");

	a_ring_no_double: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ringing_q) |-> !$past(last_match_q) || $past(!fire))
		else $error("alarm rang on a repeated match");
`endif

endmodule

[rtl/csac_out_stage.sv]
`timescale 1ns / 1ps

module csac_out_stage import csac_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  csac_result_t result,
	input  logic         out_stall,
	output logic         out_valid,
	output logic         out_free,
	output csac_result_t result_q
);

	logic valid_q;

	assign out_free  = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= fire;
		end
	end

	// hold the result while stalled
	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

endmodule

[rtl/clock_set_and_alarm_controller.sv]
`timescale 1ns / 1ps

// Clock time-set and alarm controller. Each request is a key press, an RTC
// sample or a millisecond tick, and each gives exactly one result. The block
// takes one request every clock cycle unless in_stall is raised; a result
// passes the input register and then the result register, which the state
// update loads when the output is free, before it is presented. Stalling
// the output only holds the input side once both registers are full.
// blink_half_period may be written through the cfg channel while no request
// is in flight; it is always ready.
module clock_set_and_alarm_controller import csac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] blink_half_period,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [2:0]  key_code,
	input  logic [6:0]  rtc_year,
	input  logic [3:0]  rtc_month,
	input  logic [4:0]  rtc_day,
	input  logic [4:0]  rtc_hour,
	input  logic [5:0]  rtc_minute,
	input  logic [5:0]  rtc_second,
	input  logic [2:0]  rtc_weekday,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  mode,
	output logic [2:0]  field_select,
	output logic        blank_selected,
	output logic        write_time,
	output logic        ring,
	output logic        alarm_on,
	output logic [4:0]  alarm_hour_out,
	output logic [5:0]  alarm_minute_out,
	output logic [35:0] time_word
);

	csac_item_t   in_item;
	csac_item_t   item_s1;
	csac_result_t result;
	csac_result_t result_q;
	logic         fire;
	logic         out_free;

	assign cfg_ready = 1'b1;

	assign in_item.req_type    = req_type;
	assign in_item.key_code    = key_code;
	assign in_item.rtc_year    = rtc_year;
	assign in_item.rtc_month   = rtc_month;
	assign in_item.rtc_day     = rtc_day;
	assign in_item.rtc_hour    = rtc_hour;
	assign in_item.rtc_minute  = rtc_minute;
	assign in_item.rtc_second  = rtc_second;
	assign in_item.rtc_weekday = rtc_weekday;

	csac_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_free (out_free),
		.fire     (fire),
		.item_s1  (item_s1)
	);

	csac_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (blink_half_period),
		.fire     (fire),
		.item     (item_s1),
		.result   (result)
	);

	csac_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.result    (result),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_free  (out_free),
		.result_q  (result_q)
	);

	assign mode             = result_q.mode;
	assign field_select     = result_q.field_select;
	assign blank_selected   = result_q.blank_selected;
	assign write_time       = result_q.write_time;
	assign ring             = result_q.ring;
	assign alarm_on         = result_q.alarm_on;
	assign alarm_hour_out   = result_q.alarm_hour_out;
	assign alarm_minute_out = result_q.alarm_minute_out;
	assign time_word        = result_q.time_word;

`ifndef SYNTHESIS
	a_commit_in_show: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_time) |-> (mode == MODE_SHOW))
		else $error("time commit outside show mode");

	a_blank_only_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && blank_selected) |-> (mode != MODE_SHOW))
		else $error("field blanked in show mode");

	a_commit_not_ringing: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_time) |-> !alarm_on || !ring || (time_word[32:27] == 6'd0))
		else $error("time committed while alarm silenced path was active");
`endif

endmodule
